// ===== design/gbr_pkg.sv =====
`timescale 1ns / 1ps
package gbr_pkg;

  // fixed field widths
  localparam int GW          = 11;
  localparam int PIX_W       = 8;
  localparam int WGT_W       = 16;
  localparam int RAD_W       = 3;
  localparam int NUM_WEIGHTS = 5;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int GEOM_MAX    = 2047;
  localparam int PIX_MAX     = 255;

  // default sizing
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_4 = 4'd7;

  // register reset values
  localparam logic [RAD_W-1:0] RST_RADIUS   = 3'd1;
  localparam logic [GW-1:0]    RST_WIDTH    = 11'd1024;
  localparam logic [GW-1:0]    RST_HEIGHT   = 11'd1024;
  localparam logic [WGT_W-1:0] RST_WEIGHT_0 = 16'd29611;
  localparam logic [WGT_W-1:0] RST_WEIGHT_1 = 16'd17962;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [GW-1:0]    width;
    logic [GW-1:0]    height;
  } geom_t;

  typedef logic [NUM_WEIGHTS-1:0][WGT_W-1:0] weights_t;

  // one queued request: optional store write, optional output job
  typedef struct packed {
    logic             wr;
    logic             first;
    logic [PIX_W-1:0] pix;
    logic             em;
    logic             fe;
    logic [GW-1:0]    ox;
    logic [GW-1:0]    oy;
  } item_t;

endpackage

// ===== design/gbr_if.sv =====
`timescale 1ns / 1ps
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_in;
  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface gbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/gbr_queue.sv =====
`timescale 1ns / 1ps
module gbr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gbr_pkg::item_t  push_item,
  input  logic            pop,
  output gbr_pkg::item_t  head,
  output logic            full,
  output logic            empty
);
  import gbr_pkg::*;

  item_t             buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = buf_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== design/gbr_front.sv =====
`timescale 1ns / 1ps
module gbr_front #(
  parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gbr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [7:0]              pixel_in,
  input  gbr_pkg::geom_t          geom,
  input  logic                    restart,
  input  logic                    hold,
  output logic                    push,
  output gbr_pkg::item_t          push_item,
  input  logic                    q_full
);
  import gbr_pkg::*;

  localparam int MW    = (MAX_WIDTH > GEOM_MAX) ? GEOM_MAX : MAX_WIDTH;
  localparam int MH    = (MAX_HEIGHT > GEOM_MAX) ? GEOM_MAX : MAX_HEIGHT;
  localparam int CNT_W = $clog2(MW * MH + 1);

  logic [CNT_W-1:0] in_cnt_r, out_cnt_r;
  logic [CNT_W-1:0] total_r, lag_r;
  logic [GW-1:0]    ox_r, oy_r;

  logic             accept, pix_wr, em, fe;
  logic [CNT_W-1:0] in_nxt;
  logic [CNT_W:0]   due;

  // frame size and output lag, settled before any request
  always_ff @(posedge clk) begin
    total_r <= CNT_W'({11'b0, geom.width} * {11'b0, geom.height});
    lag_r   <= CNT_W'(geom.width) * CNT_W'(geom.radius) + CNT_W'(geom.radius) + 1'b1;
  end

  // classify the request
  always_comb begin
    in_ready = !q_full && !hold;
    accept   = in_valid && in_ready;
    pix_wr   = !req_type && (in_cnt_r < total_r);
    in_nxt   = in_cnt_r + CNT_W'(pix_wr);
    due      = {1'b0, out_cnt_r} + {1'b0, lag_r};
    em       = (in_nxt == total_r) || ({1'b0, in_nxt} >= due);
    fe       = ((out_cnt_r + 1'b1) == total_r);
    push     = accept && (pix_wr || em);
    push_item.wr    = pix_wr;
    push_item.first = (in_cnt_r == '0);
    push_item.pix   = pixel_in;
    push_item.em    = em;
    push_item.fe    = fe;
    push_item.ox    = ox_r;
    push_item.oy    = oy_r;
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
    end else if (accept) begin
      if (em && fe) begin
        in_cnt_r  <= '0;
        out_cnt_r <= '0;
        ox_r      <= '0;
        oy_r      <= '0;
      end else begin
        in_cnt_r <= in_nxt;
        if (em) begin
          out_cnt_r <= out_cnt_r + 1'b1;
          if (ox_r == geom.width - 1'b1) begin
            ox_r <= '0;
            oy_r <= oy_r + 1'b1;
          end else begin
            ox_r <= ox_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== design/gbr_back.sv =====
`timescale 1ns / 1ps
module gbr_back #(
  parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = gbr_pkg::DEF_MAX_RADIUS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gbr_pkg::geom_t     geom,
  input  gbr_pkg::weights_t  weights,
  input  logic               q_empty,
  input  gbr_pkg::item_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pixel_out,
  output logic               frame_end
);
  import gbr_pkg::*;

  localparam int MW     = (MAX_WIDTH > GEOM_MAX) ? GEOM_MAX : MAX_WIDTH;
  localparam int LS_MIN = 2 * MAX_RADIUS * MW + 2 * MAX_RADIUS + 1;
  localparam int AW     = $clog2(LS_MIN);
  localparam int DEPTH  = 1 << AW;
  localparam int TAP_W  = $clog2(2 * MAX_RADIUS + 1);
  localparam int TAPS   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int PW_W   = 2 * WGT_W;
  localparam int PR_W   = PIX_W + PW_W;
  localparam int ACC_W  = PR_W + $clog2(TAPS);
  localparam int SW     = GW + 2;

  // reflect-101 about the frame edges
  function automatic logic [GW-1:0] mirror(input logic signed [SW-1:0] s,
                                           input logic [GW-1:0] n);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] nm1;
    nm1 = $signed({2'b0, n}) - SW'(1);
    t = s;
    if (t < 0) t = -t;
    if (t > nm1) t = (nm1 <<< 1) - t;
    if (t < 0) t = '0;
    if (t > nm1) t = nm1;
    return t[GW-1:0];
  endfunction

  function automatic logic [WGT_W-1:0] wsel(input logic [3:0] a, input weights_t w);
    logic [WGT_W-1:0] v;
    case (a)
      4'd0:    v = w[0];
      4'd1:    v = w[1];
      4'd2:    v = w[2];
      4'd3:    v = w[3];
      4'd4:    v = w[4];
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [PIX_W-1:0] mem [DEPTH];

  back_state_t      state_r, state_nxt;
  logic [AW-1:0]    wr_ptr_r, wa;
  logic [GW-1:0]    cx_r, cy_r;
  logic             fe_r;
  logic [TAP_W-1:0] dx_r, dy_r;
  logic             start, issue, last_tap;

  logic             a_v_r, a_last_r;
  logic [GW-1:0]    a_p_r, a_q_r;
  logic [WGT_W-1:0] a_wy_r, a_wx_r;
  logic             b_v_r, b_last_r;
  logic [AW-1:0]    b_addr_r;
  logic [PW_W-1:0]  b_w_r;
  logic             c_v_r, c_last_r;
  logic [PIX_W-1:0] c_pix_r;
  logic [PW_W-1:0]  c_w_r;
  logic             d_v_r, d_last_r;
  logic [PR_W-1:0]  d_prod_r;
  logic [ACC_W-1:0] acc_r, acc_sum;
  logic [ACC_W-PW_W-1:0] acc_int;
  logic             out_valid_r, out_fe_r;
  logic [PIX_W-1:0] out_pix_r, sat_pix;

  logic [3:0]           r2;
  logic signed [4:0]    ddx, ddy;
  logic [3:0]           adx, ady;
  logic [GW-1:0]        p_c, q_c;

  assign out_valid = out_valid_r;
  assign pixel_out = out_pix_r;
  assign frame_end = out_fe_r;

  // sequencer: pop requests, then walk the window taps
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    r2        = {geom.radius, 1'b0};
    last_tap  = (4'(dx_r) == r2) && (4'(dy_r) == r2);
    case (state_r)
      B_IDLE: begin
        if (!q_empty && (!q_head.em || !out_valid_r || out_ready)) begin
          q_pop = 1'b1;
          if (q_head.em) begin
            start     = 1'b1;
            state_nxt = B_RUN;
          end
        end
      end
      B_RUN: begin
        issue = 1'b1;
        if (last_tap) state_nxt = B_DRAIN;
      end
      B_DRAIN: begin
        if (d_v_r && d_last_r) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // tap offsets, mirrored positions and weights
  always_comb begin
    ddx = $signed({1'b0, 4'(dx_r)}) - $signed({2'b0, geom.radius});
    ddy = $signed({1'b0, 4'(dy_r)}) - $signed({2'b0, geom.radius});
    adx = (ddx < 0) ? 4'(-ddx) : 4'(ddx);
    ady = (ddy < 0) ? 4'(-ddy) : 4'(ddy);
    q_c = mirror($signed({2'b0, cx_r}) + SW'(ddx), geom.width);
    p_c = mirror($signed({2'b0, cy_r}) + SW'(ddy), geom.height);
  end

  // rounding off the sum: truncate, then saturate
  always_comb begin
    acc_sum = acc_r + ACC_W'(d_prod_r);
    acc_int = acc_sum[ACC_W-1:PW_W];
    sat_pix = (acc_int > (ACC_W-PW_W)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : acc_int[PIX_W-1:0];
    wa      = q_head.first ? '0 : wr_ptr_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_head.wr) wr_ptr_r <= wa + 1'b1;
      a_v_r <= issue;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      if (d_v_r && d_last_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr) mem[wa] <= q_head.pix;
    c_pix_r <= mem[b_addr_r];
  end

  // job, tap counters and multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (start) begin
      cx_r  <= q_head.ox;
      cy_r  <= q_head.oy;
      fe_r  <= q_head.fe;
      dx_r  <= '0;
      dy_r  <= '0;
      acc_r <= '0;
    end else begin
      if (issue) begin
        if (4'(dx_r) == r2) begin
          dx_r <= '0;
          dy_r <= dy_r + 1'b1;
        end else begin
          dx_r <= dx_r + 1'b1;
        end
      end
      if (d_v_r) acc_r <= acc_sum;
    end
    a_last_r <= last_tap;
    a_p_r    <= p_c;
    a_q_r    <= q_c;
    a_wy_r   <= wsel(ady, weights);
    a_wx_r   <= wsel(adx, weights);
    b_last_r <= a_last_r;
    b_addr_r <= AW'({11'b0, a_p_r} * {11'b0, geom.width} + {11'b0, a_q_r});
    b_w_r    <= a_wy_r * a_wx_r;
    c_last_r <= b_last_r;
    c_w_r    <= b_w_r;
    d_last_r <= c_last_r;
    d_prod_r <= c_pix_r * c_w_r;
    if (d_v_r && d_last_r) begin
      out_pix_r <= sat_pix;
      out_fe_r  <= fe_r;
    end
  end

  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> !out_valid_r)
    else $error("result held while a window is in progress");

  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (d_v_r && d_last_r) |-> (state_r == B_DRAIN))
    else $error("last tap reached accumulator outside drain");

  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == B_DRAIN))
    else $error("result appeared without a finished window");

endmodule

// ===== design/gaussian_blur_reflect_border.sv =====
`timescale 1ns / 1ps
// Streaming Gaussian blur, 8-bit grey, reflect-101 border.
// in_bus: one request per handshake; req_type 0 carries a raster pixel,
//   1 is a flush tick sent after the last pixel to drain remaining outputs.
// out_bus: filtered pixel plus frame_end on the last pixel of the frame.
// cfg_bus: index/data writes, always ready; geometry writes restart the frame.
// Output k is due when pixel k + r*W + r arrives; the window engine then
//   reads one store tap per cycle through a line store with one read port
//   and a two-multiplier chain.
// A request that only writes a pixel goes straight into the line store; a
//   request that yields an output holds the engine until its window is done.
// A four-entry queue decouples the input from the window engine.
// Reset (rst_n, synchronous) and any config write hold in_ready low while
//   frame sizes settle; the line store is not cleared.
// When the receiver stalls, the result stays in the output register; the
//   input side keeps taking requests until the queue fills.
module gaussian_blur_reflect_border #(
  parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gbr_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = gbr_pkg::DEF_MAX_RADIUS
) (
  input  logic      clk,
  input  logic      rst_n,
  gbr_in_if.sink    in_bus,
  gbr_out_if.source out_bus,
  gbr_cfg_if.sink   cfg_bus
);
  import gbr_pkg::*;

  localparam int MW = (MAX_WIDTH > GEOM_MAX) ? GEOM_MAX : MAX_WIDTH;
  localparam int MH = (MAX_HEIGHT > GEOM_MAX) ? GEOM_MAX : MAX_HEIGHT;

  logic [RAD_W-1:0] radius_r;
  logic [GW-1:0]    width_r, height_r;
  weights_t         weights_r;
  geom_t            geom_r, geom_nxt;
  logic [1:0]       settle_r;
  logic             cfg_wr, restart_r;
  logic [RAD_W-1:0] r_c;

  logic  push, q_pop, q_full, q_empty;
  item_t push_item, q_head;

  assign cfg_bus.ready = 1'b1;
  assign cfg_wr        = cfg_bus.valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RST_RADIUS;
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      weights_r[0] <= RST_WEIGHT_0;
      weights_r[1] <= RST_WEIGHT_1;
      weights_r[2] <= '0;
      weights_r[3] <= '0;
      weights_r[4] <= '0;
      settle_r     <= 2'd2;
      restart_r    <= 1'b0;
    end else begin
      restart_r <= 1'b0;
      if (settle_r != 2'd0) settle_r <= settle_r - 1'b1;
      if (cfg_wr) begin
        settle_r <= 2'd2;
        case (cfg_bus.index)
          REG_RADIUS: begin
            radius_r  <= cfg_bus.data[RAD_W-1:0];
            restart_r <= 1'b1;
          end
          REG_WIDTH: begin
            width_r   <= cfg_bus.data[GW-1:0];
            restart_r <= 1'b1;
          end
          REG_HEIGHT: begin
            height_r  <= cfg_bus.data[GW-1:0];
            restart_r <= 1'b1;
          end
          REG_WEIGHT_0: weights_r[0] <= cfg_bus.data;
          REG_WEIGHT_1: weights_r[1] <= cfg_bus.data;
          REG_WEIGHT_2: weights_r[2] <= cfg_bus.data;
          REG_WEIGHT_3: weights_r[3] <= cfg_bus.data;
          REG_WEIGHT_4: weights_r[4] <= cfg_bus.data;
          default: ;
        endcase
      end
    end
  end

  // effective geometry: clamp sizes, drop radius that does not fit
  always_comb begin
    geom_nxt.width = (width_r == '0) ? GW'(1) :
                     (width_r > GW'(MW)) ? GW'(MW) : width_r;
    geom_nxt.height = (height_r == '0) ? GW'(1) :
                      (height_r > GW'(MH)) ? GW'(MH) : height_r;
    r_c = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    geom_nxt.radius = (GW'(r_c) >= geom_nxt.width || GW'(r_c) >= geom_nxt.height) ?
                      '0 : r_c;
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  gbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .req_type  (in_bus.req_type),
    .pixel_in  (in_bus.pixel_in),
    .geom      (geom_r),
    .restart   (restart_r),
    .hold      (settle_r != 2'd0),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  gbr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gbr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom_r),
    .weights   (weights_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .pixel_out (out_bus.pixel_out),
    .frame_end (out_bus.frame_end)
  );

endmodule

// ===== tb/tb_gaussian_blur_reflect_border.sv =====
`timescale 1ns / 1ps
module tb_gaussian_blur_reflect_border;
  import gbr_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXR = 4;
  localparam int LS_DEPTH = 2 * MAXR * MAXW + 2 * MAXR + 1;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd9;

  typedef struct packed {
    logic             flush;
    logic [PIX_W-1:0] pix;
  } blur_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fe;
  } blur_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gbr_in_if  in_bus ();
  gbr_out_if out_bus ();
  gbr_cfg_if cfg_bus ();

  gaussian_blur_reflect_border i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source),
    .cfg_bus(cfg_bus.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0] mdl_store [LS_DEPTH];
  int unsigned      mdl_in_cnt, mdl_out_cnt;
  logic [RAD_W-1:0] mdl_rad;
  logic [GW-1:0]    mdl_w, mdl_h;
  logic [WGT_W-1:0] mdl_wgt [NUM_WEIGHTS];

  blur_req_t pend_q [$];
  blur_res_t exp_q [$];
  int        mismatches = 0;
  int        n_results = 0;
  int        n_frames = 0;
  int        hold_cycles = 0;
  int        items_sent = 0;
  bit        src_pause = 1'b0;

  function automatic int reflect101(int p, int n);
    if (p < 0) p = -p;
    if (p > n - 1) p = 2 * (n - 1) - p;
    if (p < 0) p = 0;
    if (p > n - 1) p = n - 1;
    return p;
  endfunction

  function automatic longint unsigned tap_weight(int off);
    int a;
    a = off < 0 ? -off : off;
    return a < NUM_WEIGHTS ? longint'(mdl_wgt[a]) : 0;
  endfunction

  function automatic int unsigned eff_w();
    return mdl_w == 0 ? 1 : (mdl_w > MAXW ? MAXW : mdl_w);
  endfunction

  function automatic int unsigned eff_h();
    return mdl_h == 0 ? 1 : (mdl_h > MAXH ? MAXH : mdl_h);
  endfunction

  // window sum at raster index k
  function automatic logic [PIX_W-1:0] blur_at(int unsigned k, int unsigned w,
                                               int unsigned h, int unsigned r);
    int y, x, p, q;
    longint unsigned acc;
    acc = 0;
    y = k / w;
    x = k % w;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      p = reflect101(y + dy, h);
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        q = reflect101(x + dx, w);
        acc += longint'(mdl_store[(p * w + q) % LS_DEPTH]) * tap_weight(dy) * tap_weight(dx);
      end
    end
    acc = acc >> (2 * WGT_W);
    return acc > PIX_MAX ? PIX_MAX : acc[PIX_W-1:0];
  endfunction

  // advance predictor by one accepted request
  task automatic predict_blur(blur_req_t rq);
    int unsigned w, h, r, total, lag;
    blur_res_t res;
    w = eff_w();
    h = eff_h();
    r = mdl_rad > MAXR ? MAXR : mdl_rad;
    if (r >= w || r >= h) r = 0;
    total = w * h;
    lag = r * w + r + 1;
    if (!rq.flush && mdl_in_cnt < total) begin
      mdl_store[mdl_in_cnt % LS_DEPTH] = rq.pix;
      mdl_in_cnt++;
    end
    if (mdl_out_cnt >= total) return;
    if (!(mdl_in_cnt == total || mdl_in_cnt >= mdl_out_cnt + lag)) return;
    res.pix = blur_at(mdl_out_cnt, w, h, r);
    mdl_out_cnt++;
    res.fe = (mdl_out_cnt == total);
    if (res.fe) begin
      mdl_in_cnt = 0;
      mdl_out_cnt = 0;
    end
    exp_q.insert(exp_q.size(), res);
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.req_type <= 1'b0;
      in_bus.pixel_in <= '0;
    end else if (in_bus.valid && !in_bus.ready) begin
      // hold the offered request
    end else begin
      if (in_bus.valid) begin
        predict_blur({in_bus.req_type, in_bus.pixel_in});
        src_gap <= rand_gap();
      end
      if (in_bus.valid || src_gap == 0) begin
        if (pend_q.size() > 0 && !src_pause && (in_bus.valid ? rand_gap() == 0 : 1'b1)) begin
          in_bus.valid <= 1'b1;
          {in_bus.req_type, in_bus.pixel_in} <= pend_q.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end else begin
        src_gap <= src_gap - 1;
        in_bus.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  int snk_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (out_bus.frame_end) n_frames++;
        if (exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result pix=%0d fe=%0b", out_bus.pixel_out,
                     out_bus.frame_end);
        end else begin
          blur_res_t e;
          e = exp_q.pop_front();
          if (e.pix !== out_bus.pixel_out || e.fe !== out_bus.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp pix=%0d fe=%0b got pix=%0d fe=%0b",
                       n_results, e.pix, e.fe, out_bus.pixel_out, out_bus.frame_end);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_bus.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        snk_gap <= rand_gap();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_RADIUS: mdl_rad = val[RAD_W-1:0];
      REG_WIDTH:  mdl_w = val[GW-1:0];
      REG_HEIGHT: mdl_h = val[GW-1:0];
      REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3, REG_WEIGHT_4:
        mdl_wgt[idx - REG_WEIGHT_0] = val[WGT_W-1:0];
      default: ;
    endcase
    if (idx == REG_RADIUS || idx == REG_WIDTH || idx == REG_HEIGHT) begin
      mdl_in_cnt = 0;
      mdl_out_cnt = 0;
    end
  endtask

  // wait until queue drained and the engine is quiet
  task automatic settle();
    while (pend_q.size() > 0 || in_bus.valid || exp_q.size() > 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  // queue one request for the driver
  task automatic add_req(blur_req_t rq);
    pend_q.insert(pend_q.size(), rq);
    items_sent++;
  endtask

  task automatic push_frame(int unsigned w, int unsigned h, int mode);
    blur_req_t rq;
    int unsigned rr;
    rr = mdl_rad > MAXR ? MAXR : mdl_rad;
    if (rr >= eff_w() || rr >= eff_h()) rr = 0;
    for (int unsigned i = 0; i < w * h; i++) begin
      rq.flush = 1'b0;
      case (mode)
        0: rq.pix = PIX_W'($urandom_range(0, 255));
        1: rq.pix = 8'hFF;
        2: rq.pix = 8'h00;
        default: rq.pix = (i & 1) ? 8'hFF : 8'h00;
      endcase
      add_req(rq);
      if ($urandom_range(0, 99) < 2) begin
        rq.flush = 1'b1;
        rq.pix = PIX_W'($urandom_range(0, 255));
        add_req(rq);
      end
    end
    // enough flush ticks to drain the outputs still owed
    for (int unsigned i = 0; i < rr * w + rr + 2; i++) begin
      rq.flush = 1'b1;
      rq.pix = PIX_W'($urandom_range(0, 255));
      add_req(rq);
    end
    // one extra pixel after completion begins the next frame
    rq.flush = 1'b0;
    rq.pix = PIX_W'($urandom_range(0, 255));
    add_req(rq);
  endtask

  task automatic set_geom(int r, int w, int h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic set_weights(int unsigned w0, int unsigned w1, int unsigned w2,
                             int unsigned w3, int unsigned w4);
    write_reg(REG_WEIGHT_0, w0);
    write_reg(REG_WEIGHT_1, w1);
    write_reg(REG_WEIGHT_2, w2);
    write_reg(REG_WEIGHT_3, w3);
    write_reg(REG_WEIGHT_4, w4);
  endtask

  initial begin
    int r, w, h, wr;
    int frame_no;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = 1'b0;
    in_bus.pixel_in = '0;
    out_bus.ready = 1'b0;
    mdl_rad = RST_RADIUS;
    mdl_w = RST_WIDTH;
    mdl_h = RST_HEIGHT;
    mdl_wgt[0] = RST_WEIGHT_0;
    mdl_wgt[1] = RST_WEIGHT_1;
    for (int i = 2; i < NUM_WEIGHTS; i++) mdl_wgt[i] = '0;
    mdl_in_cnt = 0;
    mdl_out_cnt = 0;
    frame_no = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: early flush ignored, small frames, saturation, border cases
    set_geom(1, 4, 3);
    add_req({1'b1, 8'h5A});
    push_frame(4, 3, 1);
    settle();
    set_weights(65535, 65535, 65535, 65535, 65535);
    push_frame(4, 3, 3);
    settle();
    set_geom(7, 1, 1);
    write_reg(REG_NONE, 32'hFFFF);
    push_frame(1, 1, 0);
    settle();
    set_weights(0, 0, 0, 0, 0);
    set_geom(4, 5, 5);
    push_frame(5, 5, 2);
    settle();

    // hold off the receiver so the queue fills and the input stalls
    set_weights(29611, 17962, 0, 0, 0);
    set_geom(1, 6, 4);
    push_frame(6, 4, 0);
    hold_cycles = 400;
    settle();

    // random geometries and weights
    while (items_sent < 1000) begin
      r = $urandom_range(0, 7);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) % 40 : $urandom_range(1, 12);
      h = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) h = 2047 % 16;
      wr = $urandom_range(0, 3);
      if (wr == 0) set_weights($urandom, $urandom, $urandom, $urandom, $urandom);
      else if (wr == 1) set_weights(29611, 17962, 0, 0, 0);
      else set_weights($urandom_range(0, 30000), $urandom_range(0, 20000),
                       $urandom_range(0, 12000), $urandom_range(0, 6000),
                       $urandom_range(0, 3000));
      set_geom(r, w, h);
      w = w == 0 ? 1 : w;
      h = h == 0 ? 1 : h;
      push_frame(w, h, $urandom_range(0, 9) == 0 ? 1 : 0);
      // sender pause mid-frame until all results are back
      if (frame_no == 0 || $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 40)) @(posedge clk);
        src_pause = 1'b1;
        while (exp_q.size() > 0 || in_bus.valid) @(posedge clk);
        src_pause = 1'b0;
      end
      frame_no++;
      settle();
    end

    $display("covered %0d results in %0d frames from %0d requests, radius 0..7, widths up to 39",
             n_results, n_frames, items_sent);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
design/gbr_pkg.sv
design/gbr_if.sv
design/gbr_queue.sv
design/gbr_front.sv
design/gbr_back.sv
design/gaussian_blur_reflect_border.sv
tb/tb_gaussian_blur_reflect_border.sv
